@@ design/toc_pkg.sv @@
`timescale 1ns / 1ps
package toc_pkg;

  localparam int IvW  = 20;   // interval width
  localparam int OfW  = 21;   // offset width
  localparam int RtW  = 28;   // reference time and totals
  localparam int EtW  = 37;   // Q.8 edge time
  localparam int EwW  = 38;   // edge arithmetic headroom
  localparam int QW   = 25;   // quotient, 24 fraction bits
  localparam int FrW  = 24;   // fraction bits of a factor
  localparam int CsW  = 24;   // min spacing width
  localparam int AoW  = 28;   // adjusted offset width
  localparam int AcW  = 62;   // product accumulator
  localparam int LoW  = 18;   // low slice of an edge magnitude
  localparam int StW  = 5;    // divider step counter

  typedef enum logic [3:0] {
    S_LOAD, S_DIV1, S_A_RD, S_A_MUL, S_A_WR, S_CHK, S_DIV2,
    S_B_RD, S_B_M0, S_B_M1, S_B_EDGE, S_B_EMIT
  } toc_state_e;

  typedef struct packed {
    logic [RtW-1:0]        rtime;
    logic signed [OfW-1:0] off;
  } toc_ld_t;

  typedef struct packed {
    logic           start;
    logic [EtW-1:0] dividend;
    logic [EtW-1:0] divisor;
  } toc_div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } toc_div_rsp_t;

endpackage

@@ design/toc_in_if.sv @@
`timescale 1ns / 1ps
interface toc_in_if;
  logic                             valid;
  logic                             ready;
  logic [toc_pkg::IvW-1:0]          interval;
  logic signed [toc_pkg::OfW-1:0]   offset;
  logic                             last;

  modport source (output valid, interval, offset, last, input ready);
  modport sink   (input valid, interval, offset, last, output ready);
endinterface

@@ design/toc_out_if.sv @@
`timescale 1ns / 1ps
interface toc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [toc_pkg::AoW-1:0]   adjusted_offset;
  logic                             end_of_run;

  modport source (output valid, adjusted_offset, end_of_run, input ready);
  modport sink   (input valid, adjusted_offset, end_of_run, output ready);
endinterface

@@ design/toc_div.sv @@
`timescale 1ns / 1ps
module toc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  toc_pkg::toc_div_req_t req_i,
  output toc_pkg::toc_div_rsp_t rsp_o
);
  import toc_pkg::*;

  logic [EwW-1:0] rem_q;
  logic [EtW-1:0] dvs_q;
  logic [QW-1:0]  quot_q;
  logic [StW-1:0] step_q;
  logic           busy_q, done_q;
  logic [EwW-1:0] shl, dvs_x, a_x, d_x;
  logic           ge, first;

  // one quotient bit per cycle; the remainder stays below the divisor when the dividend is below twice the divisor
  always_comb begin
    shl   = {rem_q[EwW-2:0], 1'b0};
    dvs_x = {1'b0, dvs_q};
    ge    = (shl >= dvs_x);
    a_x   = {1'b0, req_i.dividend};
    d_x   = {1'b0, req_i.divisor};
    first = (a_x >= d_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StW'(QW - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q  <= req_i.divisor;
      rem_q  <= first ? (a_x - d_x) : a_x;
      quot_q <= {{(QW-1){1'b0}}, first};
    end else if (busy_q) begin
      rem_q  <= ge ? (shl - dvs_x) : shl;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ design/timing_offset_conditioner_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Word
// in_i      in   valid/ready   interval, offset, last
// out_o     out  valid/ready   adjusted_offset, end_of_run
// cfg       in   cfg_we_i      min_spacing (cfg_wdata_i)
//
// Loading takes one word per cycle. After the last word the block computes
// with input ready low: up to two divisions in the shared divider (each
// skipped when no scaling is needed), an edge-building pass over the N
// loaded offsets, one check step and then one result per loaded offset.
// Reset clears counters, totals and min_spacing; the memories are not cleared.
// A stalled output holds the sequencer in its emit step.
module timing_offset_conditioner_top #(
  parameter int MAX_OFFSETS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [toc_pkg::CsW-1:0]   cfg_wdata_i,
  toc_in_if.sink                    in_i,
  toc_out_if.source                 out_o
);
  import toc_pkg::*;

  localparam int IW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int CW = $clog2(MAX_OFFSETS + 1);

  toc_state_e state_q, state_d;

  // memories: loaded words and edge times
  toc_ld_t               ld_mem [MAX_OFFSETS];
  logic signed [EtW-1:0] ed_mem [MAX_OFFSETS];
  toc_ld_t               ld_rd_q;
  logic signed [EtW-1:0] ed_rd_q;

  logic [CW-1:0]         cnt_q, n_q, j_q;
  logic [RtW-1:0]        rt_q, total_q;
  logic signed [RtW-1:0] ot_q;
  logic [CsW-1:0]        c_q;
  logic [CsW+CW-1:0]     cn_q;
  logic                  sc1_q, sc2_q, f2neg_q, neg_q;
  logic [QW-1:0]         f1_q, f2_q;
  logic signed [EtW-1:0] prev_q;
  logic [AcW-1:0]        acc_q;
  logic                  ov_q, eor_q;
  logic signed [AoW-1:0] aoff_q;

  toc_div_req_t div_req;
  toc_div_rsp_t div_rsp;

  logic                  in_acc, out_free, j_end;
  logic [RtW-1:0]        total_in;
  logic [OfW-1:0]        offmag;
  logic signed [OfW-1:0] off_s;
  logic [OfW-1:0]        qm1;
  logic signed [EtW-1:0] e_nom, e_new, e_scl, e_sel;
  logic signed [EwW-1:0] spaced, tot256, num, d_w;
  logic [EwW-1:0]        nummag;
  logic [EtW-1:0]        emag, sm2;
  logic signed [EwW-1:0] d_r;
  logic signed [AoW+1:0] d_t;
  logic signed [AoW-1:0] d_sat;
  logic                  ot_gt, rescale;

  toc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // datapath helpers
  always_comb begin
    in_acc   = in_i.valid & in_i.ready;
    out_free = !ov_q || out_o.ready;
    j_end    = (j_q == n_q - 1'b1);
    total_in = rt_q + RtW'(in_i.interval);
    ot_gt    = ot_q > $signed({1'b0, total_in[RtW-2:0]});
    offmag   = ld_rd_q.off[OfW-1] ? OfW'(-ld_rd_q.off) : OfW'(ld_rd_q.off);
    qm1      = acc_q[FrW +: OfW];
    off_s    = !sc1_q ? ld_rd_q.off : (neg_q ? -$signed(qm1) : $signed(qm1));
    e_nom    = EtW'(($signed({1'b0, ld_rd_q.rtime}) + RtW'(off_s)) * 256);
    spaced   = EwW'(prev_q) + $signed(EwW'(c_q));
    e_new    = (EwW'(e_nom) > spaced) ? e_nom : EtW'(spaced);
    tot256   = $signed({2'b0, total_q, 8'b0});
    rescale  = EwW'(prev_q) > tot256;
    num      = tot256 - $signed(EwW'(cn_q));
    nummag   = num[EwW-1] ? EwW'(-num) : EwW'(num);
    emag     = ed_rd_q[EtW-1] ? EtW'(-ed_rd_q) : EtW'(ed_rd_q);
    sm2      = acc_q[FrW +: EtW];
    e_scl    = neg_q ? -$signed(sm2) : $signed(sm2);
    e_sel    = sc2_q ? e_scl : ed_rd_q;
    d_w      = EwW'(prev_q) - $signed({2'b0, ld_rd_q.rtime, 8'b0});
    d_r      = d_w + (d_w[EwW-1] ? EwW'(255) : EwW'(0));
    d_t      = (AoW+2)'(d_r >>> 8);
    if (d_t > (AoW+2)'(2**(AoW-1) - 1)) d_sat = {1'b0, {(AoW-1){1'b1}}};
    else if (d_t < -(AoW+2)'(2**(AoW-1))) d_sat = {1'b1, {(AoW-1){1'b0}}};
    else d_sat = AoW'(d_t);
  end

  // sequencer next state and divider requests
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = EtW'(total_in);
    div_req.divisor  = EtW'($unsigned(ot_q));
    unique case (state_q)
      S_LOAD: begin
        if (in_acc && in_i.last && cnt_q != '0) begin
          if (ot_gt) begin
            div_req.start = 1'b1;
            state_d = S_DIV1;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_DIV1:   if (div_rsp.done) state_d = S_A_RD;
      S_A_RD:   state_d = S_A_MUL;
      S_A_MUL:  state_d = S_A_WR;
      S_A_WR:   state_d = j_end ? S_CHK : S_A_RD;
      S_CHK: begin
        div_req.dividend = EtW'(nummag);
        div_req.divisor  = EtW'($unsigned(prev_q));
        if (rescale) begin
          div_req.start = 1'b1;
          state_d = S_DIV2;
        end else begin
          state_d = S_B_RD;
        end
      end
      S_DIV2:   if (div_rsp.done) state_d = S_B_RD;
      S_B_RD:   state_d = S_B_M0;
      S_B_M0:   state_d = S_B_M1;
      S_B_M1:   state_d = S_B_EDGE;
      S_B_EDGE: state_d = S_B_EMIT;
      S_B_EMIT: if (out_free) state_d = j_end ? S_LOAD : S_B_RD;
      default:  state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else         state_q <= state_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rt_q  <= '0;
      ot_q  <= '0;
      c_q   <= '0;
      j_q   <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (cfg_we_i) c_q <= cfg_wdata_i;
      // raise valid on a new word, drop it once the word is taken
      if (state_q == S_B_EMIT && out_free) ov_q <= 1'b1;
      else if (out_o.ready)                 ov_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          j_q <= '0;
          if (in_acc) begin
            if (in_i.last) begin
              cnt_q <= '0;
              rt_q  <= '0;
              ot_q  <= '0;
            end else if (cnt_q < CW'(MAX_OFFSETS)) begin
              cnt_q <= cnt_q + 1'b1;
              rt_q  <= total_in;
              ot_q  <= ot_q + RtW'(in_i.offset);
            end
          end
        end
        S_A_WR:   j_q <= j_end ? '0 : j_q + 1'b1;
        S_B_EMIT: begin
          if (out_free) j_q <= j_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cn_q <= c_q * n_q;
    case (state_q)
      S_LOAD: begin
        n_q     <= cnt_q;
        total_q <= total_in;
        sc1_q   <= ot_gt;
        sc2_q   <= 1'b0;
        prev_q  <= '0;
      end
      S_DIV1:   f1_q <= div_rsp.quot;
      S_A_MUL: begin
        acc_q <= AcW'(offmag) * AcW'(f1_q);
        neg_q <= ld_rd_q.off[OfW-1];
      end
      S_A_WR:   prev_q <= e_new;
      S_CHK: begin
        sc2_q   <= rescale;
        f2neg_q <= num[EwW-1];
        if (!rescale) prev_q <= '0;
      end
      S_DIV2: begin
        f2_q   <= div_rsp.quot;
        prev_q <= '0;
      end
      S_B_M0: begin
        acc_q <= AcW'(emag[LoW-1:0]) * AcW'(f2_q);
        neg_q <= ed_rd_q[EtW-1] ^ f2neg_q;
      end
      S_B_M1:   acc_q <= acc_q + ((AcW'(emag[EtW-1:LoW]) * AcW'(f2_q)) << LoW);
      S_B_EDGE: prev_q <= (EwW'(e_sel) > spaced) ? e_sel : EtW'(spaced);
      S_B_EMIT: begin
        if (out_free) begin
          aoff_q <= d_sat;
          eor_q  <= j_end;
        end
      end
      default: ;
    endcase
  end

  // memory ports: write loaded words, write edges, registered reads
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && in_acc && !in_i.last && cnt_q < CW'(MAX_OFFSETS)) begin
      ld_mem[cnt_q[IW-1:0]] <= '{rtime: total_in, off: in_i.offset};
    end
    if (state_q == S_A_WR) ed_mem[j_q[IW-1:0]] <= e_new;
    ld_rd_q <= ld_mem[j_q[IW-1:0]];
    ed_rd_q <= ed_mem[j_q[IW-1:0]];
  end

  assign in_i.ready            = (state_q == S_LOAD);
  assign out_o.valid           = ov_q;
  assign out_o.adjusted_offset = aoff_q;
  assign out_o.end_of_run      = eor_q;

endmodule
